[src/fapr_pkg.sv]
// Shared types and constants for the fan after-run and precharge relay timer.
package fapr_pkg;

	localparam int unsigned MS_PER_SEC  = 1000;
	localparam int unsigned SEC_PER_MIN = 60;

	localparam int unsigned MS_W   = 10;
	localparam int unsigned SEC_W  = 6;
	localparam int unsigned MIN_W  = 16;
	localparam int unsigned CHG_W  = 16;
	localparam int unsigned REG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	localparam logic [MS_W-1:0]  MS_LAST  = MS_W'(MS_PER_SEC - 1);
	localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SEC_PER_MIN - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_FAN_HOLD_MINUTES     = 2'd0,
		REG_UNDERVOLT_LEVEL      = 2'd1,
		REG_UNDERVOLT_HYSTERESIS = 2'd2,
		REG_RELAY_DELAY_MS       = 2'd3
	} reg_idx_t;

	// One tick as it leaves the input register toward the state logic.
	typedef struct packed {
		logic              step;       // item advances and init is done
		logic              running;
		logic              test_mode;
		logic              undervolt_fault;
		logic [REG_W-1:0]  bus_voltage;
	} tick_t;

	typedef struct packed {
		logic [REG_W-1:0] undervolt_level;
		logic [REG_W-1:0] undervolt_hysteresis;
		logic [REG_W-1:0] relay_delay_ms;
	} chg_cfg_t;

endpackage

[src/fapr_fan_timer.sv]
// Fan after-run counters: ms, seconds and minutes after the drive stops.
module fapr_fan_timer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fapr_pkg::tick_t            tick,
	input  logic [fapr_pkg::REG_W-1:0] fan_hold_minutes,
	output logic                       fan_next
);

	logic                        fan_state_q;
	logic [fapr_pkg::MS_W-1:0]   ms_q;
	logic [fapr_pkg::SEC_W-1:0]  sec_q;
	logic [fapr_pkg::MIN_W-1:0]  min_q;

	logic                        fan_d;
	logic [fapr_pkg::MS_W-1:0]   ms_d;
	logic [fapr_pkg::SEC_W-1:0]  sec_d;
	logic [fapr_pkg::MIN_W-1:0]  min_d;
	logic [fapr_pkg::MIN_W-1:0]  min_inc;

	assign min_inc = min_q + fapr_pkg::MIN_W'(1);

	always_comb begin
		fan_d = fan_state_q;
		ms_d  = ms_q;
		sec_d = sec_q;
		min_d = min_q;
		if (tick.running) begin
			fan_d = 1'b1;
			ms_d  = '0;
			sec_d = '0;
			min_d = '0;
		end else if (fan_state_q) begin
			if (fan_hold_minutes != '0) begin
				if (ms_q >= fapr_pkg::MS_LAST) begin
					ms_d = '0;
					if (sec_q >= fapr_pkg::SEC_LAST) begin
						sec_d = '0;
						min_d = min_inc;
						if (min_inc >= fan_hold_minutes) begin
							fan_d = 1'b0;
							min_d = '0;
						end
					end else begin
						sec_d = sec_q + fapr_pkg::SEC_W'(1);
					end
				end else begin
					ms_d = ms_q + fapr_pkg::MS_W'(1);
				end
			end else begin
				fan_d = 1'b0;
				ms_d  = '0;
				sec_d = '0;
				min_d = '0;
			end
		end
	end

	assign fan_next = tick.step ? fan_d : fan_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_state_q <= 1'b0;
			ms_q        <= '0;
			sec_q       <= '0;
			min_q       <= '0;
		end else if (tick.step) begin
			fan_state_q <= fan_d;
			ms_q        <= ms_d;
			sec_q       <= sec_d;
			min_q       <= min_d;
		end
	end

endmodule

[src/fapr_precharge.sv]
// Precharge qualification counter and completion flag.
module fapr_precharge (
	input  logic                clk,
	input  logic                arst_n,
	input  fapr_pkg::tick_t     tick,
	input  fapr_pkg::chg_cfg_t  cfg,
	output logic                flag_next
);

	logic [fapr_pkg::CHG_W-1:0] count_q;
	logic                       flag_q;
	logic [fapr_pkg::CHG_W-1:0] count_d;
	logic                       flag_d;
	logic [fapr_pkg::REG_W:0]   threshold;
	logic                       below;
	logic                       above;

	// The sum is one bit wider so it never wraps.
	assign threshold = {1'b0, cfg.undervolt_level} + {1'b0, cfg.undervolt_hysteresis};
	assign below     = tick.bus_voltage < cfg.undervolt_level;
	assign above     = {1'b0, tick.bus_voltage} > threshold;

	always_comb begin
		count_d = count_q;
		flag_d  = flag_q;
		if (tick.test_mode) begin
			flag_d = 1'b1;
		end else if (below) begin
			if (!tick.running) begin
				count_d = '0;
				flag_d  = 1'b0;
			end
		end else if (!flag_q) begin
			if (!tick.undervolt_fault && above) begin
				if (count_q >= cfg.relay_delay_ms) begin
					flag_d = 1'b1;
				end else begin
					count_d = count_q + fapr_pkg::CHG_W'(1);
				end
			end else begin
				count_d = '0;
			end
		end
	end

	assign flag_next = tick.step ? flag_d : flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
		end else if (tick.step) begin
			count_q <= count_d;
			flag_q  <= flag_d;
		end
	end

endmodule

[src/fan_afterrun_and_precharge_relay_timer.sv]
// Top level: input register, fan and precharge state logic, result register.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    init_done running test_mode bus_voltage
//                                             undervolt_fault
//  out      output     out_valid / out_stall  fan_on relay_on charge_done
//  wr       input      wr_en                  wr_index wr_data
//
// One item per clock cycle sustained while out_stall is low; each item passes through the input
// register and its result is presented from the result register.
// The state update happens when the item moves from the input register to the
// result register, so a stalled output freezes the state along with the pipeline.
// in_stall rises only while both registers hold items and out_stall is high.
// Reset clears the counters, flags, configuration and both valid bits.
module fan_afterrun_and_precharge_relay_timer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       init_done,
	input  logic                       running,
	input  logic                       test_mode,
	input  logic [15:0]                bus_voltage,
	input  logic                       undervolt_fault,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       fan_on,
	output logic                       relay_on,
	output logic                       charge_done,
	input  logic                       wr_en,
	input  logic [fapr_pkg::IDX_W-1:0] wr_index,
	input  logic [fapr_pkg::REG_W-1:0] wr_data
);

	logic [fapr_pkg::REG_W-1:0] fan_hold_minutes_q;
	fapr_pkg::chg_cfg_t         chg_cfg_q;

	logic                       valid_s1;
	logic                       init_done_s1;
	logic                       running_s1;
	logic                       test_mode_s1;
	logic [15:0]                bus_voltage_s1;
	logic                       undervolt_fault_s1;

	logic                       advance;
	fapr_pkg::tick_t            tick;
	logic                       fan_next;
	logic                       flag_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_hold_minutes_q <= '0;
			chg_cfg_q          <= '0;
		end else if (wr_en) begin
			unique case (fapr_pkg::reg_idx_t'(wr_index))
				fapr_pkg::REG_FAN_HOLD_MINUTES:     fan_hold_minutes_q <= wr_data;
				fapr_pkg::REG_UNDERVOLT_LEVEL:      chg_cfg_q.undervolt_level <= wr_data;
				fapr_pkg::REG_UNDERVOLT_HYSTERESIS: chg_cfg_q.undervolt_hysteresis <= wr_data;
				fapr_pkg::REG_RELAY_DELAY_MS:       chg_cfg_q.relay_delay_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			init_done_s1       <= init_done;
			running_s1         <= running;
			test_mode_s1       <= test_mode;
			bus_voltage_s1     <= bus_voltage;
			undervolt_fault_s1 <= undervolt_fault;
		end
	end

	assign tick.step            = advance && init_done_s1;
	assign tick.running         = running_s1;
	assign tick.test_mode       = test_mode_s1;
	assign tick.undervolt_fault = undervolt_fault_s1;
	assign tick.bus_voltage     = bus_voltage_s1;

	fapr_fan_timer u_fan (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (tick),
		.fan_hold_minutes (fan_hold_minutes_q),
		.fan_next         (fan_next)
	);

	fapr_precharge u_chg (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.cfg       (chg_cfg_q),
		.flag_next (flag_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!(out_valid && out_stall)) begin
			out_valid <= valid_s1;
		end
	end

	// The relay is held open until initialization is done.
	always_ff @(posedge clk) begin
		if (advance) begin
			fan_on      <= fan_next;
			charge_done <= flag_next;
			relay_on    <= init_done_s1 && (test_mode_s1 ? fan_next : flag_next);
		end
	end

endmodule

[src/fapr_checker.sv]
// Port-level checks for the fan after-run and precharge relay timer, with its bind.
module fapr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic fan_on,
	input logic relay_on,
	input logic charge_done
);

	// A result waiting at the output keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({fan_on, relay_on, charge_done}))
		else $error("stalled result item changed");

	// A closed relay always comes with a completed precharge.
	a_relay_needs_charge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_on |-> charge_done)
		else $error("relay closed without completed precharge");

	// With the output register empty the input side never stalls.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	// A stall on the input side is only ever passed back from the output side.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall)
		else $error("input stalled without output stall");

endmodule

bind fan_afterrun_and_precharge_relay_timer fapr_checker u_fapr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.fan_on      (fan_on),
	.relay_on    (relay_on),
	.charge_done (charge_done)
);
